>>> rtl/fp16_elementwise_alu_macros.svh
// assertion macros for the fp16 element-wise alu
`ifndef FP16_ELEMENTWISE_ALU_MACROS_SVH
`define FP16_ELEMENTWISE_ALU_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FP16EW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define FP16EW_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FP16EW_ASSERT(label, prop, msg)
`define FP16EW_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> rtl/fp16ew_pkg.sv
// types and constants shared by the fp16 element-wise alu stages
`timescale 1ns / 1ps
package fp16ew_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_MUL = 2'd1,
        FUNC_MAX = 2'd2,
        FUNC_MIN = 2'd3
    } func_t;

    localparam logic [15:0] QNAN_DEFAULT = 16'hFE00;
    localparam logic [15:0] QUIET_BIT    = 16'h0200;
    localparam logic [15:0] INF_MAG      = 16'h7C00;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic [40:0]        mag;
        logic signed [7:0]  expo;
    } fp16ew_s1_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic [40:0]        mag;
        logic signed [7:0]  expo;
        logic [5:0]         len;
    } fp16ew_s2_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic [24:0]        mag;
        logic signed [7:0]  expo;
        logic [5:0]         len;
    } fp16ew_s3_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic               special;
        logic [15:0]        spec_val;
        logic               sign;
        logic [11:0]        rnd;
        logic signed [7:0]  expo;
    } fp16ew_s4_t;

    function automatic logic is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1f) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic is_inf(input logic [15:0] h);
        return h[14:0] == INF_MAG[14:0];
    endfunction

endpackage

>>> rtl/fp16ew_decode.sv
// first stage: special operands, max/min, exact add and multiply of significands
`timescale 1ns / 1ps
module fp16ew_decode (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [1:0]              func,
    input  logic [15:0]             operand_a,
    input  logic [15:0]             operand_b,
    input  logic                    last_in,
    output fp16ew_pkg::fp16ew_s1_t  s1
);
    import fp16ew_pkg::*;

    fp16ew_s1_t s1_reg, s1_next;

    logic [10:0]        ga, gb;
    logic [4:0]         ea, eb;
    logic [40:0]        ma, mb;
    logic [21:0]        prod;
    logic               sa, sb;
    logic signed [16:0] ka, kb;
    logic               zero_a, zero_b;

    always_comb begin
        sa     = operand_a[15];
        sb     = operand_b[15];
        ea     = (operand_a[14:10] == 5'd0) ? 5'd1 : operand_a[14:10];
        eb     = (operand_b[14:10] == 5'd0) ? 5'd1 : operand_b[14:10];
        ga     = {operand_a[14:10] != 5'd0, operand_a[9:0]};
        gb     = {operand_b[14:10] != 5'd0, operand_b[9:0]};
        ma     = 41'(ga) << (ea - 5'd1);
        mb     = 41'(gb) << (eb - 5'd1);
        prod   = 22'(ga) * 22'(gb);
        zero_a = operand_a[14:0] == 15'd0;
        zero_b = operand_b[14:0] == 15'd0;
        ka     = sa ? -$signed({2'b0, operand_a[14:0]}) : $signed({2'b0, operand_a[14:0]});
        kb     = sb ? -$signed({2'b0, operand_b[14:0]}) : $signed({2'b0, operand_b[14:0]});

        s1_next          = '0;
        s1_next.valid    = in_valid;
        s1_next.last     = last_in;
        s1_next.expo     = -8'sd24;
        case (func_t'(func))
            FUNC_ADD: begin
                if (is_nan(operand_a)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_a | QUIET_BIT;
                end else if (is_nan(operand_b)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_b | QUIET_BIT;
                end else if (is_inf(operand_a) && is_inf(operand_b)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = (sa == sb) ? operand_a : QNAN_DEFAULT;
                end else if (is_inf(operand_a)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_a;
                end else if (is_inf(operand_b)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_b;
                end
                if (sa == sb) begin
                    s1_next.mag  = ma + mb;
                    s1_next.sign = sa;
                end else if (ma > mb) begin
                    s1_next.mag  = ma - mb;
                    s1_next.sign = sa;
                end else if (mb > ma) begin
                    s1_next.mag  = mb - ma;
                    s1_next.sign = sb;
                end else begin
                    s1_next.mag  = '0;
                    s1_next.sign = 1'b0;
                end
            end
            FUNC_MUL: begin
                if (is_nan(operand_a)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_a | QUIET_BIT;
                end else if (is_nan(operand_b)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = operand_b | QUIET_BIT;
                end else if (is_inf(operand_a) || is_inf(operand_b)) begin
                    s1_next.special  = 1'b1;
                    s1_next.spec_val = (zero_a || zero_b) ? QNAN_DEFAULT :
                                       ({sa ^ sb, 15'd0} | INF_MAG);
                end
                s1_next.sign = sa ^ sb;
                s1_next.mag  = 41'(prod);
                s1_next.expo = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 8'sd50;
            end
            default: begin
                s1_next.special = 1'b1;
                if (is_nan(operand_b)) begin
                    s1_next.spec_val = operand_b | QUIET_BIT;
                end else if (is_nan(operand_a) || (zero_a && zero_b)) begin
                    s1_next.spec_val = operand_b;
                end else if (func_t'(func) == FUNC_MAX) begin
                    s1_next.spec_val = (ka > kb) ? operand_a : operand_b;
                end else begin
                    s1_next.spec_val = (ka < kb) ? operand_a : operand_b;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else if (en) begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

>>> rtl/fp16ew_norm.sv
// stages two and three: leading-one search and rounding to a 24-bit significand
`timescale 1ns / 1ps
module fp16ew_norm (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  fp16ew_pkg::fp16ew_s1_t  s1,
    output fp16ew_pkg::fp16ew_s3_t  s3
);
    import fp16ew_pkg::*;

    fp16ew_s2_t s2_reg, s2_next;
    fp16ew_s3_t s3_reg, s3_next;

    logic [5:0]  sh;
    logic [40:0] q;
    logic        halfb, sticky, up;

    always_comb begin
        s2_next = '{valid: s1.valid, last: s1.last, special: s1.special,
                    spec_val: s1.spec_val, sign: s1.sign, mag: s1.mag,
                    expo: s1.expo, len: 6'd0};
        for (int i = 0; i < 41; i++) begin
            if (s1.mag[i]) begin
                s2_next.len = 6'(i + 1);
            end
        end
    end

    always_comb begin
        s3_next = '{valid: s2_reg.valid, last: s2_reg.last, special: s2_reg.special,
                    spec_val: s2_reg.spec_val, sign: s2_reg.sign,
                    mag: s2_reg.mag[24:0], expo: s2_reg.expo, len: s2_reg.len};
        sh     = '0;
        q      = '0;
        halfb  = 1'b0;
        sticky = 1'b0;
        up     = 1'b0;
        if (s2_reg.len > 6'd24) begin
            sh     = s2_reg.len - 6'd24;
            q      = s2_reg.mag >> sh;
            halfb  = s2_reg.mag[sh - 6'd1];
            sticky = |(s2_reg.mag & ((41'd1 << (sh - 6'd1)) - 41'd1));
            up     = halfb && (sticky || q[0]);
            s3_next.mag  = q[24:0] + 25'(up);
            s3_next.expo = s2_reg.expo + $signed({2'b0, sh});
            s3_next.len  = s3_next.mag[24] ? 6'd25 : 6'd24;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
        end else if (en) begin
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign s3 = s3_reg;

endmodule

>>> rtl/fp16ew_round.sv
// stage four: align to the half-precision grid and round to nearest even
`timescale 1ns / 1ps
module fp16ew_round (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  fp16ew_pkg::fp16ew_s3_t  s3,
    output fp16ew_pkg::fp16ew_s4_t  s4
);
    import fp16ew_pkg::*;

    fp16ew_s4_t s4_reg, s4_next;

    logic signed [7:0] tt, sd;
    logic [4:0]        sh;
    logic [24:0]       q;
    logic              halfb, sticky, up;

    always_comb begin
        tt = s3.expo + $signed({2'b0, s3.len}) - 8'sd11;
        if (tt < -8'sd24) begin
            tt = -8'sd24;
        end
        sd     = tt - s3.expo;
        sh     = '0;
        q      = '0;
        halfb  = 1'b0;
        sticky = 1'b0;
        up     = 1'b0;
        s4_next = '{valid: s3.valid, last: s3.last, special: s3.special,
                    spec_val: s3.spec_val, sign: s3.sign, rnd: 12'd0, expo: tt};
        if (sd > 8'sd0) begin
            sh     = sd[4:0];
            q      = s3.mag >> sh;
            halfb  = s3.mag[sh - 5'd1];
            sticky = |(s3.mag & ((25'd1 << (sh - 5'd1)) - 25'd1));
            up     = halfb && (sticky || q[0]);
            s4_next.rnd = q[11:0] + 12'(up);
        end else begin
            s4_next.rnd = 12'(s3.mag << 5'(-sd));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_reg.valid <= 1'b0;
        end else if (en) begin
            s4_reg <= s4_next;
        end
    end

    assign s4 = s4_reg;

endmodule

>>> rtl/fp16ew_pack.sv
// stage five: exponent encoding, overflow to infinity, output register
`timescale 1ns / 1ps
module fp16ew_pack (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  fp16ew_pkg::fp16ew_s4_t  s4,
    output logic                    out_valid,
    output logic [15:0]             result,
    output logic                    last_out
);
    import fp16ew_pkg::*;

    logic        valid_reg;
    logic [15:0] result_reg, result_next;
    logic        last_reg;

    logic [11:0]       r;
    logic signed [7:0] t, bexp;

    always_comb begin
        r = s4.rnd;
        t = s4.expo;
        if (r[11]) begin
            r = r >> 1;
            t = t + 8'sd1;
        end
        bexp = t + 8'sd25;
        if (s4.special) begin
            result_next = s4.spec_val;
        end else if (!r[10]) begin
            result_next = {s4.sign, 5'd0, r[9:0]};
        end else if (bexp >= 8'sd31) begin
            result_next = {s4.sign, 15'd0} | INF_MAG;
        end else begin
            result_next = {s4.sign, bexp[4:0], r[9:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg  <= s4.valid;
            result_reg <= result_next;
            last_reg   <= s4.last;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;
    assign last_out  = last_reg;

endmodule

>>> rtl/fp16_elementwise_alu.sv
// top level of the fp16 element-wise add / multiply / max / min unit
`timescale 1ns / 1ps
`include "fp16_elementwise_alu_macros.svh"
// Takes one request per cycle while nothing stalls and presents its results on m_tdata in
// order; the five-stage pipeline (decode, leading-one search, binary32 rounding, binary16
// rounding, packing) advances as a whole whenever the output register is empty or being
// taken, so a stall at m_tready holds every stage and s_tready follows it; s_tready stays
// low while aresetn is low.
module fp16_elementwise_alu (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand_a, operand_b
    input  logic [1:0]  s_tuser,   // func
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // result
    output logic        m_tlast    // last_out
);
    import fp16ew_pkg::*;

    logic       en;
    fp16ew_s1_t s1;
    fp16ew_s3_t s3;
    fp16ew_s4_t s4;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && aresetn;

    fp16ew_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .func      (s_tuser),
        .operand_a (s_tdata[15:0]),
        .operand_b (s_tdata[31:16]),
        .last_in   (s_tlast),
        .s1        (s1)
    );

    fp16ew_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s1      (s1),
        .s3      (s3)
    );

    fp16ew_round u_round (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s3      (s3),
        .s4      (s4)
    );

    fp16ew_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s4        (s4),
        .out_valid (m_tvalid),
        .result    (m_tdata),
        .last_out  (m_tlast)
    );

    `FP16EW_ASSERT(a_ready_follows_output, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `FP16EW_ASSERT(a_nan_is_quiet, (m_tvalid && m_tdata[14:10] == 5'h1f && m_tdata[9:0] != 10'd0) |-> m_tdata[9], "signaling nan out")
    `FP16EW_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid, "valid after reset")
    `FP16EW_ASSERT(a_stall_holds_stage4, (s4.valid && !en) |=> s4.valid, "stage four lost on stall")

endmodule
